// ===== hdl/smm_pkg.sv =====
// Shared types and constants for the square matrix multiplier.
// Holds the input and output word layouts and the command codes; no dependencies.
package smm_pkg;

    localparam logic [1:0] CMD_LOAD_A  = 2'd0;
    localparam logic [1:0] CMD_LOAD_B  = 2'd1;
    localparam logic [1:0] CMD_COMPUTE = 2'd2;

    localparam logic [3:0] SIZE_RESET  = 4'd8;
    localparam int         IDX_W       = 3;
    localparam int         ELEM_W      = 16;
    localparam int         PROD_W      = 2 * ELEM_W;
    localparam int         ACC_W       = 36;
    // wide enough for row * 8 + col with 3-bit indexes
    localparam int         ADDR_CALC_W = 6;

    typedef struct packed {
        logic [1:0]               command;
        logic [IDX_W-1:0]         row_index;
        logic [IDX_W-1:0]         col_index;
        logic signed [ELEM_W-1:0] element_value;
    } t_in_word;

    typedef struct packed {
        logic [IDX_W-1:0]        out_row;
        logic [IDX_W-1:0]        out_col;
        logic signed [ACC_W-1:0] product_value;
        logic                    last_element;
    } t_out_word;

    // control tag that travels with each multiply-accumulate step
    typedef struct packed {
        logic             valid;
        logic             first_k;
        logic             last_k;
        logic             last;
        logic [IDX_W-1:0] i;
        logic [IDX_W-1:0] j;
    } t_mac_tag;

endpackage

// ===== hdl/smm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependencies.
module smm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic                                 i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // hold read data while not enabled
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/square_matrix_multiply.sv =====
// Square matrix multiplier C = A x B on signed Q8.8 elements, exact Q20.16 sums.
// Load words (A or B element by row and column) are accepted whenever the block is idle.
// A compute word stalls the input until the last result enters the output register: one
// shared multiplier and accumulator performs one multiply-accumulate per cycle unless
// the output stalls, fed by one read port on each matrix RAM, and the n*n results leave
// in row-major order, last one flagged. Depends on smm_pkg and smm_ram.
module square_matrix_multiply #(
    parameter int MAX_DIM = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  smm_pkg::t_in_word i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output smm_pkg::t_out_word o_out_data,
    input  logic              i_cfg_we,
    input  logic [3:0]        i_cfg_data
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN
    } t_state;

    t_state                        r_state, n_state;
    logic [3:0]                    r_size;
    logic [3:0]                    r_dim, n_dim;
    logic [smm_pkg::IDX_W-1:0]     r_i, n_i, r_j, n_j, r_k, n_k;
    smm_pkg::t_mac_tag             r_s1, n_s1, r_s2, n_s2;
    logic signed [smm_pkg::PROD_W-1:0] r_prod, n_prod;
    logic signed [smm_pkg::ACC_W-1:0]  r_acc, n_acc;
    logic                          r_out_valid, n_out_valid;
    smm_pkg::t_out_word            r_out, n_out;

    logic                          adv;
    logic                          in_accept;
    logic                          in_range;
    logic [3:0]                    clamp_dim;
    logic [smm_pkg::IDX_W-1:0]     last_idx;
    logic                          we_a, we_b;
    logic [AW-1:0]                 waddr, raddr_a, raddr_b;
    logic [smm_pkg::ELEM_W-1:0]    rdata_a, rdata_b;
    logic signed [smm_pkg::ACC_W-1:0] prod_ext;
    logic signed [smm_pkg::ACC_W-1:0] acc_sum;

    // the whole MAC pipe moves only when the output register can take a word
    assign adv       = !r_out_valid || !i_out_stall;
    assign in_accept = i_in_valid && (r_state == ST_IDLE);
    assign last_idx  = smm_pkg::IDX_W'(r_dim - 4'd1);

    always_comb begin
        if (r_size == 4'd0) begin
            clamp_dim = 4'd1;
        end else if (r_size > 4'(MAX_DIM)) begin
            clamp_dim = 4'(MAX_DIM);
        end else begin
            clamp_dim = r_size;
        end
    end

    assign in_range = ({1'b0, i_in_data.row_index} < clamp_dim) &&
                      ({1'b0, i_in_data.col_index} < clamp_dim);
    assign we_a = in_accept && in_range && (i_in_data.command == smm_pkg::CMD_LOAD_A);
    assign we_b = in_accept && in_range && (i_in_data.command == smm_pkg::CMD_LOAD_B);

    assign waddr   = AW'(smm_pkg::ADDR_CALC_W'(i_in_data.row_index) *
                         smm_pkg::ADDR_CALC_W'(MAX_DIM) +
                         smm_pkg::ADDR_CALC_W'(i_in_data.col_index));
    assign raddr_a = AW'(smm_pkg::ADDR_CALC_W'(r_i) * smm_pkg::ADDR_CALC_W'(MAX_DIM) +
                         smm_pkg::ADDR_CALC_W'(r_k));
    assign raddr_b = AW'(smm_pkg::ADDR_CALC_W'(r_k) * smm_pkg::ADDR_CALC_W'(MAX_DIM) +
                         smm_pkg::ADDR_CALC_W'(r_j));

    smm_ram #(.WIDTH(smm_pkg::ELEM_W), .DEPTH(DEPTH)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (waddr),
        .i_wdata (i_in_data.element_value),
        .i_re    (adv),
        .i_raddr (raddr_a),
        .o_rdata (rdata_a)
    );

    smm_ram #(.WIDTH(smm_pkg::ELEM_W), .DEPTH(DEPTH)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (waddr),
        .i_wdata (i_in_data.element_value),
        .i_re    (adv),
        .i_raddr (raddr_b),
        .o_rdata (rdata_b)
    );

    assign prod_ext = {{(smm_pkg::ACC_W-smm_pkg::PROD_W){r_prod[smm_pkg::PROD_W-1]}}, r_prod};
    assign acc_sum  = r_s2.first_k ? prod_ext : r_acc + prod_ext;

    always_comb begin
        n_state     = r_state;
        n_dim       = r_dim;
        n_i         = r_i;
        n_j         = r_j;
        n_k         = r_k;
        n_s1        = r_s1;
        n_s2        = r_s2;
        n_prod      = r_prod;
        n_acc       = r_acc;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        unique case (r_state)
            ST_IDLE: begin
                if (in_accept && (i_in_data.command == smm_pkg::CMD_COMPUTE)) begin
                    n_dim   = clamp_dim;
                    n_i     = '0;
                    n_j     = '0;
                    n_k     = '0;
                    n_state = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                if (adv) begin
                    // advance k fastest, then column, then row
                    if (r_k == last_idx) begin
                        n_k = '0;
                        if (r_j == last_idx) begin
                            n_j = '0;
                            if (r_i == last_idx) begin
                                n_state = ST_DRAIN;
                            end else begin
                                n_i = r_i + 1'b1;
                            end
                        end else begin
                            n_j = r_j + 1'b1;
                        end
                    end else begin
                        n_k = r_k + 1'b1;
                    end
                end
            end
            ST_DRAIN: begin
                if (adv && r_s2.valid && r_s2.last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (adv) begin
            n_s1.valid   = (r_state == ST_ISSUE);
            n_s1.first_k = (r_k == '0);
            n_s1.last_k  = (r_k == last_idx);
            n_s1.last    = (r_i == last_idx) && (r_j == last_idx) && (r_k == last_idx);
            n_s1.i       = r_i;
            n_s1.j       = r_j;

            n_s2   = r_s1;
            n_prod = $signed(rdata_a) * $signed(rdata_b);

            if (r_s2.valid) begin
                n_acc = acc_sum;
            end
            n_out_valid               = r_s2.valid && r_s2.last_k;
            n_out.out_row             = r_s2.i;
            n_out.out_col             = r_s2.j;
            n_out.product_value       = acc_sum;
            n_out.last_element        = r_s2.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_size      <= smm_pkg::SIZE_RESET;
            r_s1.valid  <= 1'b0;
            r_s2.valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            if (i_cfg_we) begin
                r_size <= i_cfg_data;
            end
            r_s1.valid  <= n_s1.valid;
            r_s2.valid  <= n_s2.valid;
            r_out_valid <= n_out_valid;
        end
        r_dim         <= n_dim;
        r_i           <= n_i;
        r_j           <= n_j;
        r_k           <= n_k;
        r_s1.first_k  <= n_s1.first_k;
        r_s1.last_k   <= n_s1.last_k;
        r_s1.last     <= n_s1.last;
        r_s1.i        <= n_s1.i;
        r_s1.j        <= n_s1.j;
        r_s2.first_k  <= n_s2.first_k;
        r_s2.last_k   <= n_s2.last_k;
        r_s2.last     <= n_s2.last;
        r_s2.i        <= n_s2.i;
        r_s2.j        <= n_s2.j;
        r_prod        <= n_prod;
        r_acc         <= n_acc;
        r_out         <= n_out;
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef ASSERT_OFF
    a_idle_pipe_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (!r_s1.valid && !r_s2.valid))
        else $error("MAC pipe busy while idle");

    a_last_on_diagonal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.last_element) |->
            (o_out_data.out_row == o_out_data.out_col))
        else $error("last word not at bottom-right corner");

    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_s2.valid && r_s2.last) |=> (r_state == ST_IDLE))
        else $error("run did not end after last word");
`endif

endmodule
